// ===== rtl/core/nsf_pkg.sv =====
// ============================================================================
// nsf_pkg
// Shared constants, stage types and helper functions of the nearest-neighbor
// scaler with vertical flip for RGB565 pixel streams.
// ============================================================================
package nsf_pkg;

    // Largest frame or panel dimension; clamped dimensions saturate here.
    localparam int MAX_DIM   = 2048;

    localparam int COORD_W   = 11;
    localparam int PIX_W     = 16;
    localparam int IDX_W     = 22;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 3;

    // A clamped dimension holds 1 .. MAX_DIM.
    localparam int DIM_W     = $clog2(MAX_DIM + 1);
    // A scaled coordinate stays below the source dimension.
    localparam int Q_W       = $clog2(MAX_DIM);
    localparam int PROD_W    = COORD_W + DIM_W;
    localparam int SP_W      = 2 * DIM_W;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH    = 3'd0,
        REG_SRC_HEIGHT   = 3'd1,
        REG_PANEL_WIDTH  = 3'd2,
        REG_PANEL_HEIGHT = 3'd3,
        REG_SWAP_RB      = 3'd4
    } cfg_reg_t;

    // Input register stage.
    typedef struct packed {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [PIX_W-1:0]   pix;
    } front_t;

    // Products of the coordinates with the dimensions.
    typedef struct packed {
        logic [PROD_W-1:0]  prod_x;
        logic [PROD_W-1:0]  prod_y;
        logic [PROD_W-1:0]  prod_p;
        logic [COORD_W-1:0] px;
        logic [PIX_W-1:0]   pix;
        logic               oor;
    } mul_t;

    // One step of the two restoring dividers.
    typedef struct packed {
        logic [PROD_W-1:0] num_x;
        logic [DIM_W-1:0]  rem_x;
        logic [Q_W-1:0]    q_x;
        logic [PROD_W-1:0] num_y;
        logic [DIM_W-1:0]  rem_y;
        logic [Q_W-1:0]    q_y;
        logic [IDX_W-1:0]  pidx;
        logic [PIX_W-1:0]  pix;
        logic              oor;
    } div_t;

    // Flipped source row.
    typedef struct packed {
        logic [DIM_W-1:0] row;
        logic [Q_W-1:0]   q_x;
        logic [IDX_W-1:0] pidx;
        logic [PIX_W-1:0] pix;
        logic             oor;
    } row_t;

    // Row times source width.
    typedef struct packed {
        logic [SP_W-1:0]  prod_s;
        logic [Q_W-1:0]   q_x;
        logic [IDX_W-1:0] pidx;
        logic [PIX_W-1:0] pix;
        logic             oor;
    } idx_t;

    // Output register.
    typedef struct packed {
        logic [IDX_W-1:0] sidx;
        logic [IDX_W-1:0] pidx;
        logic [PIX_W-1:0] pix;
        logic             oor;
    } out_t;

    // A zero dimension counts as one, a large one saturates at MAX_DIM.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    // Exchange the red field (bits 15..11) and the blue field (bits 4..0).
    function automatic logic [PIX_W-1:0] swap_red_blue(input logic [PIX_W-1:0] p);
        return {p[4:0], p[10:5], p[15:11]};
    endfunction

endpackage

// ===== rtl/core/nearest_scale_flip_rgb565.sv =====
// ============================================================================
// nearest_scale_flip_rgb565
// Maps panel pixel positions to source frame positions by nearest-neighbor
// scaling with a vertical flip, and passes an RGB565 pixel through.
// ============================================================================
//
// Usage: each transfer on the s_ channel carries one panel position and the
// RGB565 pixel that goes with it. The block returns, on the m_ channel, the
// flat index of the source pixel (flipped row times source width plus
// column), the flat panel index, the pixel with red and blue optionally
// swapped, and in m_tuser a flag for positions outside the panel, for which
// both indices are zero.
// The cfg_ channel writes the five dimension and mode registers; it is always
// ready, and must be used only while no pixel is in flight, which the block
// does not enforce. The pipeline holds 16 register stages: input register,
// multiply, eleven divider steps (one quotient bit each for the column and
// row quotients), row flip, row multiply, output.
// Throughput is one pixel per clock while the receiver keeps m_tready high.
// Every stage carries its own valid bit and holds while the stage after it
// is full and stalled, so a stalled receiver only blocks s_tready once the
// whole pipeline has filled; empty stages keep taking data in the meantime.
// Reset clears all valid bits and loads the registers with 320 x 240 source,
// 240 x 320 panel and no red/blue swap.
module nearest_scale_flip_rgb565 (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [nsf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [nsf_pkg::CFG_W-1:0]            cfg_data,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0 up: panel_x[10:0], panel_y[21:11], src_pixel[37:22],
    // zero padding[39:38].
    input  logic [nsf_pkg::IN_TDATA_W-1:0]       s_tdata,

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // Fields from bit 0 up: src_index[21:0], panel_index[43:22],
    // pixel_out[59:44], zero padding[63:60].
    output logic [nsf_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // Fields from bit 0 up: out_of_range[0].
    output logic                                 m_tuser
);

    localparam int Q_W      = nsf_pkg::Q_W;
    localparam int DIM_W    = nsf_pkg::DIM_W;
    localparam int PROD_W   = nsf_pkg::PROD_W;
    localparam int SP_W     = nsf_pkg::SP_W;
    localparam int IDX_W    = nsf_pkg::IDX_W;
    localparam int COORD_W  = nsf_pkg::COORD_W;
    localparam int PIX_W    = nsf_pkg::PIX_W;
    // Stage numbering: input, multiply, divider steps, flip, row multiply, out.
    localparam int ST_MUL   = 1;
    localparam int ST_DIV0  = 2;
    localparam int ST_ROW   = ST_DIV0 + Q_W;
    localparam int ST_IDX   = ST_ROW + 1;
    localparam int ST_OUT   = ST_IDX + 1;
    localparam int NS       = ST_OUT + 1;
    localparam int OUT_PAD  = nsf_pkg::OUT_TDATA_W - 2 * IDX_W - PIX_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [nsf_pkg::CFG_W-1:0] src_width_reg;
    logic [nsf_pkg::CFG_W-1:0] src_height_reg;
    logic [nsf_pkg::CFG_W-1:0] panel_width_reg;
    logic [nsf_pkg::CFG_W-1:0] panel_height_reg;
    logic                      swap_rb_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg    <= nsf_pkg::CFG_W'(320);
            src_height_reg   <= nsf_pkg::CFG_W'(240);
            panel_width_reg  <= nsf_pkg::CFG_W'(240);
            panel_height_reg <= nsf_pkg::CFG_W'(320);
            swap_rb_reg      <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (nsf_pkg::cfg_reg_t'(cfg_index))
                nsf_pkg::REG_SRC_WIDTH:    src_width_reg    <= cfg_data;
                nsf_pkg::REG_SRC_HEIGHT:   src_height_reg   <= cfg_data;
                nsf_pkg::REG_PANEL_WIDTH:  panel_width_reg  <= cfg_data;
                nsf_pkg::REG_PANEL_HEIGHT: panel_height_reg <= cfg_data;
                nsf_pkg::REG_SWAP_RB:      swap_rb_reg      <= cfg_data[0];
                default: begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    // Configuration must change only while the pipeline is empty (the block
    // does not enforce it); stages read clamped dimensions, not carried ones.
    logic [DIM_W-1:0] sw, sh, pw, ph;
    assign sw = nsf_pkg::clamp_dim(src_width_reg);
    assign sh = nsf_pkg::clamp_dim(src_height_reg);
    assign pw = nsf_pkg::clamp_dim(panel_width_reg);
    assign ph = nsf_pkg::clamp_dim(panel_height_reg);

    // ------------------------------------------------------------------
    // Flow control: a stage may load when it is empty or when the stage
    // after it loads in the same cycle.
    // ------------------------------------------------------------------
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] adv;

    always_comb begin
        adv[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign s_tready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input stage: unpack and apply the optional red/blue swap.
    // ------------------------------------------------------------------
    nsf_pkg::front_t front_reg, front_next;

    always_comb begin
        front_next.px  = s_tdata[COORD_W-1:0];
        front_next.py  = s_tdata[2*COORD_W-1:COORD_W];
        front_next.pix = swap_rb_reg
                       ? nsf_pkg::swap_red_blue(s_tdata[2*COORD_W+PIX_W-1:2*COORD_W])
                       : s_tdata[2*COORD_W+PIX_W-1:2*COORD_W];
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            front_reg <= front_next;
        end
    end

    // ------------------------------------------------------------------
    // Multiply stage: scaled numerators, panel row offset, range check.
    // ------------------------------------------------------------------
    nsf_pkg::mul_t mul_reg, mul_next;

    always_comb begin
        mul_next.prod_x = PROD_W'(front_reg.px) * PROD_W'(sw);
        mul_next.prod_y = PROD_W'(front_reg.py) * PROD_W'(sh);
        mul_next.prod_p = PROD_W'(front_reg.py) * PROD_W'(pw);
        mul_next.px     = front_reg.px;
        mul_next.pix    = front_reg.pix;
        mul_next.oor    = (PROD_W'(front_reg.px) >= PROD_W'(pw))
                       || (PROD_W'(front_reg.py) >= PROD_W'(ph));
    end

    always_ff @(posedge aclk) begin
        if (adv[ST_MUL]) begin
            mul_reg <= mul_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider: restoring division, one quotient bit per stage, for the
    // column (divisor panel width) and the row (divisor panel height).
    // For an in-range position the quotient is below the source dimension,
    // so the numerator bits above the quotient width start as a remainder
    // that is already smaller than the divisor.
    // ------------------------------------------------------------------
    nsf_pkg::div_t div_in   [Q_W];
    nsf_pkg::div_t div_next [Q_W];
    nsf_pkg::div_t div_reg  [Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_div
        if (j == 0) begin : g_first
            always_comb begin
                div_in[j].num_x = mul_reg.prod_x;
                div_in[j].rem_x = DIM_W'(mul_reg.prod_x >> Q_W);
                div_in[j].q_x   = '0;
                div_in[j].num_y = mul_reg.prod_y;
                div_in[j].rem_y = DIM_W'(mul_reg.prod_y >> Q_W);
                div_in[j].q_y   = '0;
                div_in[j].pidx  = IDX_W'(mul_reg.prod_p + PROD_W'(mul_reg.px));
                div_in[j].pix   = mul_reg.pix;
                div_in[j].oor   = mul_reg.oor;
            end
        end else begin : g_chain
            assign div_in[j] = div_reg[j-1];
        end

        logic [DIM_W:0] trial_x, trial_y;
        logic           ge_x, ge_y;

        always_comb begin
            trial_x = {div_in[j].rem_x, div_in[j].num_x[Q_W-1-j]};
            trial_y = {div_in[j].rem_y, div_in[j].num_y[Q_W-1-j]};
            ge_x    = trial_x >= {1'b0, pw};
            ge_y    = trial_y >= {1'b0, ph};

            div_next[j]       = div_in[j];
            div_next[j].rem_x = ge_x ? DIM_W'(trial_x - {1'b0, pw}) : DIM_W'(trial_x);
            div_next[j].rem_y = ge_y ? DIM_W'(trial_y - {1'b0, ph}) : DIM_W'(trial_y);
            div_next[j].q_x   = {div_in[j].q_x[Q_W-2:0], ge_x};
            div_next[j].q_y   = {div_in[j].q_y[Q_W-2:0], ge_y};
        end

        always_ff @(posedge aclk) begin
            if (adv[ST_DIV0+j]) begin
                div_reg[j] <= div_next[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Flip stage: the source frame is stored bottom-up.
    // ------------------------------------------------------------------
    nsf_pkg::row_t row_reg, row_next;

    always_comb begin
        row_next.row  = DIM_W'(sh - DIM_W'(1) - DIM_W'(div_reg[Q_W-1].q_y));
        row_next.q_x  = div_reg[Q_W-1].q_x;
        row_next.pidx = div_reg[Q_W-1].pidx;
        row_next.pix  = div_reg[Q_W-1].pix;
        row_next.oor  = div_reg[Q_W-1].oor;
    end

    always_ff @(posedge aclk) begin
        if (adv[ST_ROW]) begin
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Row multiply stage.
    // ------------------------------------------------------------------
    nsf_pkg::idx_t idx_reg, idx_next;

    always_comb begin
        idx_next.prod_s = SP_W'(row_reg.row) * SP_W'(sw);
        idx_next.q_x    = row_reg.q_x;
        idx_next.pidx   = row_reg.pidx;
        idx_next.pix    = row_reg.pix;
        idx_next.oor    = row_reg.oor;
    end

    always_ff @(posedge aclk) begin
        if (adv[ST_IDX]) begin
            idx_reg <= idx_next;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: add the column, mask to the index width, and zero both
    // indices for positions outside the panel.
    // ------------------------------------------------------------------
    nsf_pkg::out_t out_reg, out_next;

    always_comb begin
        out_next.sidx = idx_reg.oor ? '0
                      : IDX_W'((SP_W + 1)'(idx_reg.prod_s) + (SP_W + 1)'(idx_reg.q_x));
        out_next.pidx = idx_reg.oor ? '0 : idx_reg.pidx;
        out_next.pix  = idx_reg.pix;
        out_next.oor  = idx_reg.oor;
    end

    always_ff @(posedge aclk) begin
        if (adv[ST_OUT]) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = {{OUT_PAD{1'b0}}, out_reg.pix, out_reg.pidx, out_reg.sidx};
    assign m_tuser  = out_reg.oor;

endmodule

// ===== tb/tb_nearest_scale_flip_rgb565.sv =====
// ============================================================================
// tb_nearest_scale_flip_rgb565
// Self-checking bench for the nearest-neighbor scaler with vertical flip.
// Panel positions and RGB565 pixels stream into the block while a predictor
// computes the source index, panel index, swapped pixel and out-of-panel flag.
// Every returned transfer is compared field by field with the oldest
// prediction, across many register settings and with random back-pressure.
// ============================================================================
module tb_nearest_scale_flip_rgb565;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W     = nsf_pkg::COORD_W;
    localparam int PIX_W       = nsf_pkg::PIX_W;
    localparam int IDX_W       = nsf_pkg::IDX_W;
    localparam int CFG_W       = nsf_pkg::CFG_W;
    localparam int CFG_IDX_W   = nsf_pkg::CFG_IDX_W;
    localparam int IN_TDATA_W  = nsf_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = nsf_pkg::OUT_TDATA_W;
    localparam int MAX_DIM     = nsf_pkg::MAX_DIM;

    // One panel position with the pixel that travels along with it.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   color;
    } pixel_job_t;

    // What the block should return for one position.
    typedef struct packed {
        logic [IDX_W-1:0] src_index;
        logic [IDX_W-1:0] panel_index;
        logic [PIX_W-1:0] color;
        logic             off_panel;
    } map_result_t;

    localparam int RANDOM_PHASES  = 12;
    localparam int JOBS_PER_PHASE = 125;
    localparam int FREEZE_CYCLES  = 300;

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs. Every input holds a known value from
    // time zero.
    // ------------------------------------------------------------------------
    logic                   aclk;
    logic                   aresetn   = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data  = '0;

    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // Fields from bit 0 up: panel_x, panel_y, src_pixel, zero padding.
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;

    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // Fields from bit 0 up: src_index, panel_index, pixel_out, zero padding.
    logic [OUT_TDATA_W-1:0] m_tdata;
    // Fields from bit 0 up: out_of_range.
    logic                   m_tuser;

    nearest_scale_flip_rgb565 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Shared bench state.
    // ------------------------------------------------------------------------
    pixel_job_t  pending_jobs[$];    // positions not yet offered to the block
    map_result_t expected_maps[$];   // predictions waiting for their transfer

    // Shadow copy of the register file, updated on each accepted write.
    logic [CFG_W-1:0] shadow_src_w;
    logic [CFG_W-1:0] shadow_src_h;
    logic [CFG_W-1:0] shadow_panel_w;
    logic [CFG_W-1:0] shadow_panel_h;
    logic             shadow_swap;

    pixel_job_t tx_cur;              // the job currently on s_tdata
    logic [3:0] tx_gap = '0;         // idle cycles before the next job
    logic [3:0] rx_wait = '0;        // stall cycles before taking a result
    logic       steady_flow = 1'b0;  // both sides run without idling
    logic       rx_frozen = 1'b0;    // the receiver holds off completely

    int mismatches   = 0;
    int jobs_added   = 0;
    int jobs_sent    = 0;
    int results_seen = 0;
    int off_seen     = 0;
    int reg_writes   = 0;

    // ------------------------------------------------------------------------
    // Predictor.
    // ------------------------------------------------------------------------

    // A zero register reads as one, anything past MAX_DIM as MAX_DIM.
    function automatic int unsigned dim_eff(input logic [CFG_W-1:0] v);
        if (v == '0) return 1;
        if (int'(v) > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    // Nearest-neighbor mapping under the shadow registers. The source frame
    // is stored bottom-up, so the scaled row is mirrored before the flat
    // index is formed.
    function automatic map_result_t predict_map(input pixel_job_t job);
        map_result_t r;
        int unsigned sw, sh, pw, ph, col, row;
        sw = dim_eff(shadow_src_w);
        sh = dim_eff(shadow_src_h);
        pw = dim_eff(shadow_panel_w);
        ph = dim_eff(shadow_panel_h);
        r.color = shadow_swap ? {job.color[4:0], job.color[10:5], job.color[15:11]}
                              : job.color;
        if (job.x >= pw || job.y >= ph) begin
            r.off_panel   = 1'b1;
            r.src_index   = '0;
            r.panel_index = '0;
        end else begin
            col           = (job.x * sw) / pw;
            row           = sh - 1 - (job.y * sh) / ph;
            r.off_panel   = 1'b0;
            r.src_index   = IDX_W'(row * sw + col);
            r.panel_index = IDX_W'(job.y * pw + job.x);
        end
        return r;
    endfunction

    // Prints one line for the mismatch and counts it.
    task automatic note_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Register shadow. Writes only happen while the pipeline is empty, so
    // taking them at the write transfer is exact.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            shadow_src_w   <= 12'd320;
            shadow_src_h   <= 12'd240;
            shadow_panel_w <= 12'd240;
            shadow_panel_h <= 12'd320;
            shadow_swap    <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (nsf_pkg::cfg_reg_t'(cfg_index))
                nsf_pkg::REG_SRC_WIDTH:    shadow_src_w   <= cfg_data;
                nsf_pkg::REG_SRC_HEIGHT:   shadow_src_h   <= cfg_data;
                nsf_pkg::REG_PANEL_WIDTH:  shadow_panel_w <= cfg_data;
                nsf_pkg::REG_PANEL_HEIGHT: shadow_panel_h <= cfg_data;
                nsf_pkg::REG_SWAP_RB:      shadow_swap    <= cfg_data[0];
                default: ;
            endcase
            reg_writes++;
        end
    end

    // ------------------------------------------------------------------------
    // Driver. When a job's transfer completes its prediction is queued. The
    // next job goes out once the idle count drawn with the previous one has
    // run down; the count only runs while nothing is waiting on the bus.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : drive
        pixel_job_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            tx_gap   <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_maps.push_back(predict_map(tx_cur));
                jobs_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap != 0) begin
                    tx_gap   <= tx_gap - 1'b1;
                    s_tvalid <= 1'b0;
                end else if (pending_jobs.size() != 0) begin
                    nxt      = pending_jobs.pop_front();
                    tx_cur   <= nxt;
                    s_tdata  <= {2'b00, nxt.color, nxt.y, nxt.x};
                    s_tvalid <= 1'b1;
                    tx_gap   <= steady_flow ? 4'd0 : 4'($urandom_range(0, 8));
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Each result transfer is checked against the oldest prediction.
    // After each transfer the receiver draws a stall of its own; a freeze
    // request overrides everything and keeps m_tready low.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : observe
        map_result_t want;
        logic [3:0]  stall;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  <= '0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (m_tuser) off_seen++;
                if (expected_maps.size() == 0) begin
                    note_mismatch($sformatf("result %0d arrived with nothing pending",
                                            results_seen));
                end else begin
                    want = expected_maps.pop_front();
                    if (m_tdata[IDX_W-1:0] !== want.src_index)
                        note_mismatch($sformatf("result %0d src_index %0d, expected %0d",
                            results_seen, m_tdata[IDX_W-1:0], want.src_index));
                    if (m_tdata[2*IDX_W-1:IDX_W] !== want.panel_index)
                        note_mismatch($sformatf("result %0d panel_index %0d, expected %0d",
                            results_seen, m_tdata[2*IDX_W-1:IDX_W], want.panel_index));
                    if (m_tdata[2*IDX_W+PIX_W-1:2*IDX_W] !== want.color)
                        note_mismatch($sformatf("result %0d pixel_out %h, expected %h",
                            results_seen, m_tdata[2*IDX_W+PIX_W-1:2*IDX_W], want.color));
                    if (m_tuser !== want.off_panel)
                        note_mismatch($sformatf("result %0d out_of_range %b, expected %b",
                            results_seen, m_tuser, want.off_panel));
                    if (m_tdata[OUT_TDATA_W-1:2*IDX_W+PIX_W] !== '0)
                        note_mismatch($sformatf("result %0d padding bits not zero",
                            results_seen));
                end
            end

            if (rx_frozen) begin
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                stall    = steady_flow ? 4'd0 : 4'($urandom_range(0, 8));
                rx_wait  <= stall;
                m_tready <= (stall == 0);
            end else if (rx_wait != 0) begin
                rx_wait  <= rx_wait - 1'b1;
                m_tready <= (rx_wait == 1);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. Tasks that drive signals are entered at a rising
    // edge and return at one.
    // ------------------------------------------------------------------------
    function automatic void add_job(input int x, input int y, input int color);
        pixel_job_t j;
        j.x     = COORD_W'(x);
        j.y     = COORD_W'(y);
        j.color = PIX_W'(color);
        pending_jobs.push_back(j);
        jobs_added++;
    endfunction

    // Random job under the current panel size: mostly inside the panel, some
    // right on its edges, some anywhere in the coordinate range.
    function automatic void add_random_job();
        int pw, ph, x, y;
        pw = dim_eff(shadow_panel_w);
        ph = dim_eff(shadow_panel_h);
        x  = $urandom_range(0, pw - 1);
        y  = $urandom_range(0, ph - 1);
        case ($urandom_range(0, 9))
            0: begin
                x = $urandom_range(0, 2047);
                y = $urandom_range(0, 2047);
            end
            1: x = ($urandom_range(0, 1) != 0) ? pw : pw - 1;
            2: y = ($urandom_range(0, 1) != 0) ? ph : ph - 1;
            default: ;
        endcase
        add_job(x, y, $urandom_range(0, 65535));
    endfunction

    // Returns once every queued job has been answered by a result transfer,
    // which leaves the pipeline empty.
    task automatic wait_drained();
        while (results_seen < jobs_added)
            @(posedge aclk);
    endtask

    task automatic write_reg(input nsf_pkg::cfg_reg_t idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_dims(input int sw, input int sh, input int pw, input int ph,
                              input bit swap);
        write_reg(nsf_pkg::REG_SRC_WIDTH,    CFG_W'(sw));
        write_reg(nsf_pkg::REG_SRC_HEIGHT,   CFG_W'(sh));
        write_reg(nsf_pkg::REG_PANEL_WIDTH,  CFG_W'(pw));
        write_reg(nsf_pkg::REG_PANEL_HEIGHT, CFG_W'(ph));
        write_reg(nsf_pkg::REG_SWAP_RB,      CFG_W'(swap));
    endtask

    // A random setting, from tiny frames to saturated registers, with up-
    // and downscaling and equal sizes among them.
    task automatic write_random_dims();
        int sw, sh, pw, ph;
        case ($urandom_range(0, 5))
            0: begin
                sw = $urandom_range(0, 4095);
                sh = $urandom_range(0, 4095);
                pw = $urandom_range(0, 4095);
                ph = $urandom_range(0, 4095);
            end
            1: begin
                sw = $urandom_range(1, 16);
                sh = $urandom_range(1, 16);
                pw = $urandom_range(1, 16);
                ph = $urandom_range(1, 16);
            end
            2: begin
                sw = $urandom_range(1, MAX_DIM);
                sh = $urandom_range(1, MAX_DIM);
                pw = sw;
                ph = sh;
            end
            3: begin
                sw = $urandom_range(1024, MAX_DIM);
                sh = $urandom_range(1024, MAX_DIM);
                pw = $urandom_range(1024, MAX_DIM);
                ph = $urandom_range(1024, MAX_DIM);
            end
            4: begin
                sw = $urandom_range(1, 64);
                sh = $urandom_range(1, 64);
                pw = $urandom_range(256, MAX_DIM);
                ph = $urandom_range(256, MAX_DIM);
            end
            default: begin
                sw = $urandom_range(256, MAX_DIM);
                sh = $urandom_range(256, MAX_DIM);
                pw = $urandom_range(1, 64);
                ph = $urandom_range(1, 64);
            end
        endcase
        write_dims(sw, sh, pw, ph, $urandom_range(0, 1));
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset setting: 320 x 240 source on a 240 x 320 panel. Corners of the
        // panel, a column past the edge, a row past the edge, and both.
        add_job(0, 0, 16'h0000);
        add_job(239, 319, 16'hFFFF);
        add_job(240, 5, 16'hF800);
        add_job(5, 320, 16'h001F);
        add_job(2047, 2047, 16'h07E0);
        wait_drained();

        // Equal sizes with red and blue swapped: rows must come out reversed
        // one to one.
        write_dims(64, 48, 64, 48, 1'b1);
        add_job(0, 0, 16'hF800);
        add_job(63, 47, 16'h001F);
        add_job(0, 47, 16'h1234);
        add_job(63, 0, 16'hABCD);
        wait_drained();

        // Largest legal frame and panel: full coordinate range is inside.
        write_dims(MAX_DIM, MAX_DIM, MAX_DIM, MAX_DIM, 1'b0);
        add_job(2047, 2047, 16'hFFFF);
        add_job(0, 2047, 16'h5555);
        add_job(1024, 1, 16'hAAAA);
        wait_drained();

        // Zero registers read as one and oversized ones saturate.
        write_dims(0, 4095, 4095, 0, 1'b1);
        add_job(2047, 0, 16'h8421);
        add_job(0, 0, 16'hFFFF);
        add_job(5, 1, 16'h0001);
        wait_drained();

        // A single-pixel source blown up to the full panel.
        write_dims(1, 1, MAX_DIM, MAX_DIM, 1'b0);
        add_job(100, 100, 16'h7BEF);
        add_job(2047, 2047, 16'h0000);
        wait_drained();

        // Random phases, each under a fresh setting. Some run with no idling
        // at all; one freezes the receiver while the sender keeps pushing so
        // the pipeline fills and stalls its input; one pauses the sender
        // halfway until every result is back.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_random_dims();
            steady_flow <= (ph % 4 == 1) || (ph == 6);
            if (ph == 6) begin
                fork
                    begin
                        rx_frozen <= 1'b1;
                        repeat (FREEZE_CYCLES) @(posedge aclk);
                        rx_frozen <= 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < JOBS_PER_PHASE; k++) begin
                if (ph == 3 && k == JOBS_PER_PHASE / 2) wait_drained();
                add_random_job();
            end
            wait_drained();
        end

        // Give a stray extra result time to show up.
        repeat (40) @(posedge aclk);

        $display("%0d positions mapped, %0d outside the panel, under %0d register writes",
                 jobs_sent, off_seen, reg_writes);
        $display("%0d results checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && expected_maps.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/nsf_pkg.sv
rtl/core/nearest_scale_flip_rgb565.sv
tb/tb_nearest_scale_flip_rgb565.sv
